// ----- hdl/wfsl_pkg.sv -----
// ----------------------------------------------------------------------------
// wfsl_pkg: shared types and constants
// Sequencer states, register indexes and register reset values.
// ----------------------------------------------------------------------------
package wfsl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SQ,
    ST_GAIN,
    ST_VSQ,
    ST_SQRT,
    ST_DMUL,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam logic [2:0] REG_COUNT  = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_SPEED  = 3'd2;
  localparam logic [2:0] REG_GAIN_X = 3'd3;
  localparam logic [2:0] REG_GAIN_Y = 3'd4;
  localparam logic [2:0] REG_GAIN_Z = 3'd5;

  localparam logic [6:0]  RST_COUNT  = 7'd1;
  localparam logic [31:0] RST_RADIUS = 32'd6554;
  localparam logic [31:0] RST_SPEED  = 32'd65536;
  localparam logic [23:0] RST_GAIN   = 24'd65536;

endpackage

// ----- hdl/waypoint_follower_speed_limit.sv -----
// ----------------------------------------------------------------------------
// waypoint_follower_speed_limit
// Proportional velocity command toward a stored waypoint list, with a
// speed limit applied to the vector length. Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Flow: a waypoint write beat gives no result. A position update posts
// its result after the error, arrival, gain and speed steps (a second
// error step when the target advances), plus, when the limit applies, a
// 32-step square root and three divisions (product, load, 32 steps).
// Throughput: one update at a time, the next accepted once its result is
// loaded (later on stalled results); writes go back to back when idle.
// Reset: sync, active high; registers return to their defaults, target 0.
// The waypoint memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module waypoint_follower_speed_limit import wfsl_pkg::*; #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [5:0]         entry_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic [5:0]         target_slot,
  output logic               advanced,
  output logic               limited
);

  localparam int AW  = $clog2(MAX_WAYPOINTS);
  localparam int CW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int IW  = (CW > 7) ? CW : 7;
  localparam int CAP = (MAX_WAYPOINTS < 64) ? MAX_WAYPOINTS : 64;

  // config registers
  logic [6:0]  waypoint_count;
  logic [31:0] arrival_radius;
  logic [31:0] max_speed;
  logic [23:0] gain_x, gain_y, gain_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= RST_COUNT;
      arrival_radius <= RST_RADIUS;
      max_speed      <= RST_SPEED;
      gain_x         <= RST_GAIN;
      gain_y         <= RST_GAIN;
      gain_z         <= RST_GAIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNT:  waypoint_count <= cfg_data[6:0];
        REG_RADIUS: arrival_radius <= cfg_data;
        REG_SPEED:  max_speed      <= cfg_data;
        REG_GAIN_X: gain_x         <= cfg_data[23:0];
        REG_GAIN_Y: gain_y         <= cfg_data[23:0];
        REG_GAIN_Z: gain_z         <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // effective count: zero acts as one, capped to the table size
  logic [6:0] n_eff;
  always_comb begin
    n_eff = (waypoint_count == 7'd0) ? 7'd1 : waypoint_count;
    if (n_eff > 7'(CAP)) n_eff = 7'(CAP);
  end

  state_t state, state_next;
  logic   in_acc;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // waypoint memory: {x, y, z} per entry
  logic [95:0]   mem [MAX_WAYPOINTS];
  logic [95:0]   rd_data;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [IW-1:0] ent_ext;

  assign ent_ext = IW'(entry_index);
  assign wr_en   = in_acc && !command && (ent_ext < IW'(MAX_WAYPOINTS));
  assign wr_addr = AW'(ent_ext);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {coord_x, coord_y, coord_z};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // datapath registers
  logic [5:0]  target, idx;
  logic        pass2, adv, lim;
  logic [31:0] pos [3];
  logic [31:0] emag [3];
  logic        eneg [3];
  logic [31:0] vmag [3];
  logic        vneg [3];
  logic [2:0]  step;
  logic [1:0]  ax;
  logic [4:0]  cnt;
  logic [65:0] acc;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [63:0] sx, res, bitv;
  logic [31:0] rem, dvd, quot;

  // target choice at accept and on arrival
  logic [5:0] idx_start, idx_adv;
  logic [6:0] idx_inc;
  assign idx_start = ({1'b0, target} >= n_eff) ? 6'd0 : target;
  assign idx_inc   = {1'b0, idx} + 7'd1;
  assign idx_adv   = (idx_inc >= n_eff) ? 6'd0 : idx_inc[5:0];

  logic near_hit, over, adv_now, out_load;
  assign near_hit = acc < {2'b00, prod};
  assign over     = acc > {2'b00, prod};
  assign adv_now  = (state == ST_SQ) && (step == 3'd4) && !pass2 && near_hit;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  assign rd_en   = (in_acc && command) || adv_now;
  assign rd_addr = AW'(IW'(adv_now ? idx_adv : idx_start));

  // shared 32x32 multiplier, registered
  logic [1:0] sel;
  assign sel = (step < 3'd3) ? step[1:0] : 2'd0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ: begin
        mul_a = (step < 3'd3) ? emag[sel] : arrival_radius;
        mul_b = mul_a;
      end
      ST_GAIN: begin
        mul_a = emag[sel];
        unique case (sel)
          2'd0:    mul_b = {8'd0, gain_x};
          2'd1:    mul_b = {8'd0, gain_y};
          default: mul_b = {8'd0, gain_z};
        endcase
      end
      ST_VSQ: begin
        mul_a = (step < 3'd3) ? vmag[sel] : max_speed;
        mul_b = mul_a;
      end
      ST_DMUL: begin
        mul_a = vmag[ax];
        mul_b = max_speed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && command) state_next = ST_ERR;
      ST_ERR:   state_next = pass2 ? ST_GAIN : ST_SQ;
      ST_SQ:    if (step == 3'd4) state_next = adv_now ? ST_ERR : ST_GAIN;
      ST_GAIN:  if (step == 3'd3) state_next = ST_VSQ;
      ST_VSQ:   if (step == 3'd4) state_next = over ? ST_SQRT : ST_DONE;
      ST_SQRT:  if (cnt == 5'd31) state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV:   if (cnt == 5'd31) state_next = (ax == 2'd2) ? ST_DONE : ST_DMUL;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // helpers
  logic [32:0] err_c [3];
  logic [39:0] gq;
  logic [31:0] glim;
  logic [63:0] trial;
  logic [32:0] dt;
  logic [33:0] ddiff;
  logic [31:0] qfin;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      err_c[k] = {rd_data[95 - 32*k], rd_data[95 - 32*k -: 32]}
               - {pos[k][31], pos[k]};
    end
    gq    = prod[55:16];
    glim  = eneg[step[1:0] - 2'd1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    trial = res + bitv;
    dt    = {rem, dvd[31]};
    ddiff = {1'b0, dt} - {2'b00, res[31:0]};
    qfin  = {quot[30:0], !ddiff[33]};
    if (qfin > 32'h7FFF_FFFF) qfin = 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (in_acc && !command) begin
      target <= '0;
    end else if (out_load) begin
      target <= idx;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        step <= '0;
        if (in_acc && command) begin
          pos[0] <= coord_x;
          pos[1] <= coord_y;
          pos[2] <= coord_z;
          idx    <= idx_start;
          pass2  <= 1'b0;
          adv    <= 1'b0;
          lim    <= 1'b0;
        end
      end
      ST_ERR: begin
        step <= '0;
        for (int k = 0; k < 3; k++) begin
          eneg[k] <= err_c[k][32];
          emag[k] <= err_c[k][32] ? 32'(-err_c[k]) : err_c[k][31:0];
        end
        acc <= '0;
      end
      ST_SQ: begin
        step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
        if (step != 3'd0 && step != 3'd4) acc <= acc + {2'b00, prod};
        if (adv_now) begin
          idx   <= idx_adv;
          adv   <= 1'b1;
          pass2 <= 1'b1;
        end
      end
      ST_GAIN: begin
        step <= (step == 3'd3) ? 3'd0 : step + 3'd1;
        if (step != 3'd0) begin
          vneg[step[1:0] - 2'd1] <= eneg[step[1:0] - 2'd1];
          vmag[step[1:0] - 2'd1] <= (gq > {8'd0, glim}) ? glim : gq[31:0];
        end
        if (step == 3'd3) acc <= '0;
      end
      ST_VSQ: begin
        step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
        if (step != 3'd0 && step != 3'd4) acc <= acc + {2'b00, prod};
        if (step == 3'd4) begin
          sx   <= acc[63:0];
          res  <= '0;
          bitv <= 64'd1 << 62;
          cnt  <= '0;
          ax   <= '0;
        end
      end
      ST_SQRT: begin
        if (sx >= trial) begin
          sx  <= sx - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        lim  <= 1'b1;
      end
      ST_DMUL: ;
      ST_DLOAD: begin
        rem  <= {1'b0, prod[62:32]};
        dvd  <= prod[31:0];
        quot <= '0;
        cnt  <= '0;
      end
      ST_DIV: begin
        rem  <= ddiff[33] ? dt[31:0] : ddiff[31:0];
        dvd  <= dvd << 1;
        quot <= {quot[30:0], !ddiff[33]};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          vmag[ax] <= qfin;
          ax       <= ax + 2'd1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vel_x       <= vneg[0] ? -vmag[0] : vmag[0];
      vel_y       <= vneg[1] ? -vmag[1] : vmag[1];
      vel_z       <= vneg[2] ? -vmag[2] : vmag[2];
      target_slot <= idx;
      advanced    <= adv;
      limited     <= lim;
    end
  end

  // checks
  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && command |=> state == ST_ERR)
    else $error("update did not start");

  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && !command |=> target == 6'd0)
    else $error("write left target set");

  a_done_posts: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == ST_IDLE)
    else $error("result not posted");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DLOAD |-> !prod[63])
    else $error("scaled product out of range");

endmodule
